>>> rtl/pftmc_pkg.sv
// Package for the per-flow timestamp monotonic checker.
// Holds table sizing, field widths, command and status codes and sequencer states.
// No dependencies.
package pftmc_pkg;

  localparam int unsigned TABLE_ENTRIES = 32;
  localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);

  localparam int unsigned DEV_W  = 32;
  localparam int unsigned TYPE_W = 2;
  localparam int unsigned TIME_W = 48;
  localparam int unsigned PEER_W = 32;
  localparam int unsigned CFG_W  = 32;
  localparam int unsigned CFG_IDX_W = 1;

  localparam int unsigned IN_DATA_W  = 168;
  localparam int unsigned OUT_DATA_W = 56;

  localparam logic [CFG_IDX_W-1:0] REG_REBOOT_SMALL  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_RECONNECT_GAP = 1'b1;

  localparam logic [CFG_W-1:0] REBOOT_SMALL_RST  = 32'd60000;
  localparam logic [CFG_W-1:0] RECONNECT_GAP_RST = 32'd5000;

  typedef enum logic [1:0] {
    KIND_CHECK   = 2'd0,
    KIND_CLR_DEV = 2'd1,
    KIND_CLR_ALL = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_RESET_PEER   = 3'd1,
    ST_RESET_REBOOT = 3'd2,
    ST_RESET_GAP    = 3'd3,
    ST_NON_MONO     = 3'd4,
    ST_FULL         = 3'd5,
    ST_BAD_TS       = 3'd6,
    ST_CLEARED      = 3'd7
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_EVAL,
    S_FINISH
  } state_e;

  typedef struct packed {
    logic [1:0]        kind;
    logic [DEV_W-1:0]  dev;
    logic [TYPE_W-1:0] stype;
    logic [TIME_W-1:0] ts;
    logic [TIME_W-1:0] wall;
    logic [PEER_W-1:0] peer;
  } req_t;

endpackage

>>> rtl/per_flow_timestamp_monotonic_check.sv
// Per-flow timestamp monotonic checker, top level.
// Check frame: the table is scanned one entry per cycle through the shared key compare up to
//   a key hit or the last entry, then evaluated; a new word is taken once the result is out.
// Clear one device: the same scan over every entry. Clear table, bad timestamp: no scan.
// Reset: asynchronous, clears all entry-used bits at once (table empty), loads 60000 / 5000
//   into the reboot and gap registers. Depends on pftmc_pkg.
module per_flow_timestamp_monotonic_check
  import pftmc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // input words
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // device_key[31:0], stream_type[33:32], frame_time_ms[81:34],
  // wall_now_ms[129:82], peer_addr[161:130], zero pad[167:162]
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  // kind[1:0]
  input  logic [1:0]            s_axis_tuser_i,
  // result words
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // status[2:0], prior_time_ms[50:3], zero pad[55:51]
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o,
  // configuration writes
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_W-1:0]      cfg_data_i
);

  // Configuration registers, always ready; user must write only while idle (not enforced).
  logic [CFG_W-1:0] reboot_small_q, reconnect_gap_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reboot_small_q  <= REBOOT_SMALL_RST;
      reconnect_gap_q <= RECONNECT_GAP_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_REBOOT_SMALL:  reboot_small_q  <= cfg_data_i;
        REG_RECONNECT_GAP: reconnect_gap_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Flow table. Only the used bits need reset: an entry's payload is rewritten
  // when it is claimed, so stale payload in a free entry is never observed.
  logic [TABLE_ENTRIES-1:0] used_q;
  logic [DEV_W-1:0]         dev_tbl_q  [0:TABLE_ENTRIES-1];
  logic [TYPE_W-1:0]        type_tbl_q [0:TABLE_ENTRIES-1];
  logic [TIME_W-1:0]        time_tbl_q [0:TABLE_ENTRIES-1];
  logic [TIME_W-1:0]        wall_tbl_q [0:TABLE_ENTRIES-1];
  logic [PEER_W-1:0]        peer_tbl_q [0:TABLE_ENTRIES-1];

  // Sequencer state
  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [IDX_W-1:0] slot_q, slot_d;
  logic             found_q, found_d;
  logic             free_q, free_d;
  status_e          res_status_q, res_status_d;
  logic [TIME_W-1:0] res_prior_q, res_prior_d;
  req_t             req_q;

  // Output register
  logic              m_valid_q;
  status_e           m_status_q;
  logic [TIME_W-1:0] m_prior_q;

  // Table write controls
  logic             used_clr_all, used_clr_one, used_set_one;
  logic             claim_we, upd_we;
  logic [IDX_W-1:0] wr_idx;
  logic [PEER_W-1:0] peer_wr;

  // Scan compare: the one key compare reused for every entry
  logic [IDX_W-1:0] scan_idx;
  logic             scan_last, dev_hit, key_hit;

  assign scan_idx  = cnt_q[IDX_W-1:0];
  assign scan_last = (cnt_q == CNT_W'(TABLE_ENTRIES - 1));
  assign dev_hit   = used_q[scan_idx] && (dev_tbl_q[scan_idx] == req_q.dev);
  assign key_hit   = dev_hit && (type_tbl_q[scan_idx] == req_q.stype);

  // Evaluation of the selected entry; a newly claimed entry reads as zero
  logic [TIME_W-1:0] old_time, old_wall, wall_gap;
  logic [PEER_W-1:0] old_peer;
  status_e           eval_status;

  assign old_time = found_q ? time_tbl_q[slot_q] : '0;
  assign old_wall = found_q ? wall_tbl_q[slot_q] : '0;
  assign old_peer = found_q ? peer_tbl_q[slot_q] : '0;
  assign wall_gap = req_q.wall - old_wall;

  always_comb begin
    priority if (req_q.ts > old_time) begin
      eval_status = ST_OK;
    end else if (req_q.ts == old_time) begin
      eval_status = ST_NON_MONO;
    end else if (old_peer != '0 && req_q.peer != '0 && old_peer != req_q.peer) begin
      eval_status = ST_RESET_PEER;
    end else if (req_q.ts < TIME_W'(reboot_small_q) && old_time > TIME_W'(reboot_small_q)) begin
      eval_status = ST_RESET_REBOOT;
    end else if (old_wall != '0 && req_q.wall >= old_wall
                 && wall_gap > TIME_W'(reconnect_gap_q)) begin
      eval_status = ST_RESET_GAP;
    end else begin
      eval_status = ST_NON_MONO;
    end
  end

  assign s_axis_tready_o = (state_q == S_IDLE);

  // Next state and table controls
  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    slot_d       = slot_q;
    found_d      = found_q;
    free_d       = free_q;
    res_status_d = res_status_q;
    res_prior_d  = res_prior_q;
    used_clr_all = 1'b0;
    used_clr_one = 1'b0;
    used_set_one = 1'b0;
    claim_we     = 1'b0;
    upd_we       = 1'b0;
    wr_idx       = scan_idx;
    peer_wr      = (req_q.peer != '0) ? req_q.peer : old_peer;

    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid_i) begin
          cnt_d       = '0;
          found_d     = 1'b0;
          free_d      = 1'b0;
          res_prior_d = '0;
          case (s_axis_tuser_i)
            KIND_CHECK: begin
              if (s_axis_tdata_i[81:34] == '0) begin
                res_status_d = ST_BAD_TS;
                state_d      = S_FINISH;
              end else begin
                state_d = S_SCAN;
              end
            end
            KIND_CLR_DEV: begin
              state_d = S_SCAN;
            end
            KIND_CLR_ALL: begin
              used_clr_all = 1'b1;
              res_status_d = ST_CLEARED;
              state_d      = S_FINISH;
            end
            default: begin
              // undefined command: table unchanged, answered as cleared
              res_status_d = ST_CLEARED;
              state_d      = S_FINISH;
            end
          endcase
        end
      end

      S_SCAN: begin
        cnt_d = cnt_q + CNT_W'(1);
        if (req_q.kind == KIND_CLR_DEV) begin
          // drop every entry of this device, any stream type
          used_clr_one = dev_hit;
          if (scan_last) begin
            res_status_d = ST_CLEARED;
            state_d      = S_FINISH;
          end
        end else begin
          if (!used_q[scan_idx] && !free_q) begin
            free_d = 1'b1;
            slot_d = scan_idx;
          end
          if (key_hit) begin
            found_d = 1'b1;
            slot_d  = scan_idx;
            state_d = S_EVAL;
          end else if (scan_last) begin
            state_d = S_EVAL;
          end
        end
      end

      S_EVAL: begin
        wr_idx  = slot_q;
        state_d = S_FINISH;
        if (!found_q && !free_q) begin
          res_status_d = ST_FULL;
          res_prior_d  = '0;
        end else begin
          res_status_d = eval_status;
          res_prior_d  = old_time;
          claim_we     = !found_q;
          used_set_one = !found_q;
          upd_we       = (eval_status != ST_NON_MONO);
        end
      end

      S_FINISH: begin
        // hold until the output register is free
        if (!m_valid_q || m_axis_tready_i) begin
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cnt_q        <= '0;
      slot_q       <= '0;
      found_q      <= 1'b0;
      free_q       <= 1'b0;
      res_status_q <= ST_CLEARED;
      used_q       <= '0;
      m_valid_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      cnt_q        <= cnt_d;
      slot_q       <= slot_d;
      found_q      <= found_d;
      free_q       <= free_d;
      res_status_q <= res_status_d;
      if (used_clr_all) begin
        used_q <= '0;
      end else if (used_clr_one) begin
        used_q[wr_idx] <= 1'b0;
      end else if (used_set_one) begin
        used_q[wr_idx] <= 1'b1;
      end
      if (state_q == S_FINISH && (!m_valid_q || m_axis_tready_i)) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers: request capture, result, table entries, output data
  always_ff @(posedge clk_i) begin
    res_prior_q <= res_prior_d;
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      req_q.kind  <= s_axis_tuser_i;
      req_q.dev   <= s_axis_tdata_i[31:0];
      req_q.stype <= s_axis_tdata_i[33:32];
      req_q.ts    <= s_axis_tdata_i[81:34];
      req_q.wall  <= s_axis_tdata_i[129:82];
      req_q.peer  <= s_axis_tdata_i[161:130];
    end
    if (claim_we) begin
      dev_tbl_q[wr_idx]  <= req_q.dev;
      type_tbl_q[wr_idx] <= req_q.stype;
    end
    if (upd_we) begin
      time_tbl_q[wr_idx] <= req_q.ts;
      wall_tbl_q[wr_idx] <= req_q.wall;
      peer_tbl_q[wr_idx] <= peer_wr;
    end
    if (state_q == S_FINISH && (!m_valid_q || m_axis_tready_i)) begin
      m_status_q <= res_status_q;
      m_prior_q  <= res_prior_q;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {5'b0, m_prior_q, m_status_q};

endmodule

>>> sim/tb_top.sv
// Self-checking testbench for the per-flow timestamp monotonic checker.
// Drives check and clear words with random idling and back-pressure, and predicts every result
// with its own copy of the flow table. Depends on pftmc_pkg and the checker top level.
module tb_top;
  import pftmc_pkg::*;

  localparam logic [1:0]  KIND_UNDEF  = 2'd3;  // no command, answered as cleared
  localparam int unsigned DEV_POOL    = 12;    // 12 devices x 4 types overfill the table
  localparam int unsigned PEER_POOL   = 4;
  localparam int unsigned DRAIN_LIMIT = 4000;
  localparam int unsigned RUN_LIMIT   = 5_000_000;
  localparam int unsigned PAD_W = IN_DATA_W - (DEV_W + TYPE_W + 2 * TIME_W + PEER_W);

  typedef struct packed {
    status_e           status;
    logic [TIME_W-1:0] prior;
  } verdict_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  s_axis_tvalid_i;
  logic                  s_axis_tready_o;
  logic [IN_DATA_W-1:0]  s_axis_tdata_i;
  logic [1:0]            s_axis_tuser_i;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i;
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_W-1:0]      cfg_data_i;

  // Shadow flow table, updated at each accepted word, and shadow config registers.
  bit                flow_used [TABLE_ENTRIES];
  logic [DEV_W-1:0]  flow_dev  [TABLE_ENTRIES];
  logic [TYPE_W-1:0] flow_type [TABLE_ENTRIES];
  logic [TIME_W-1:0] flow_time [TABLE_ENTRIES];
  logic [TIME_W-1:0] flow_wall [TABLE_ENTRIES];
  logic [PEER_W-1:0] flow_peer [TABLE_ENTRIES];
  logic [CFG_W-1:0]  reboot_small = REBOOT_SMALL_RST;
  logic [CFG_W-1:0]  gap_limit    = RECONNECT_GAP_RST;

  verdict_t          pending_verdicts[$];
  int unsigned       mismatch_count = 0;

  // Traffic shaping shared by the driver, the sink and the tests.
  bit                src_idle_on  = 1'b1;
  bit                sink_idle_on = 1'b1;
  int unsigned       sink_hold    = 0;
  logic [DEV_W-1:0]  dev_pool  [DEV_POOL];
  logic [PEER_W-1:0] peer_pool [PEER_POOL];
  logic [TIME_W-1:0] wall_clock = '0;

  per_flow_timestamp_monotonic_check uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic void wipe_flow(int unsigned i);
    flow_used[i] = 1'b0;
    flow_dev[i]  = '0;
    flow_type[i] = '0;
    flow_time[i] = '0;
    flow_wall[i] = '0;
    flow_peer[i] = '0;
  endfunction

  // Work out the result of one accepted word and apply its effect on the shadow table.
  function automatic verdict_t judge_word(logic [1:0] kind, logic [DEV_W-1:0] dev,
                                          logic [TYPE_W-1:0] stype, logic [TIME_W-1:0] ts,
                                          logic [TIME_W-1:0] wall, logic [PEER_W-1:0] peer);
    verdict_t    v;
    bit          found;
    bit          have_free;
    int unsigned slot;
    v.status  = ST_CLEARED;
    v.prior   = '0;
    found     = 1'b0;
    have_free = 1'b0;
    slot      = 0;
    case (kind)
      KIND_CHECK: begin
        if (ts == '0) begin
          v.status = ST_BAD_TS;
        end else begin
          // Take the matching flow, else remember the lowest free entry.
          for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (!found) begin
              if (!flow_used[i]) begin
                if (!have_free) begin
                  have_free = 1'b1;
                  slot      = i;
                end
              end else if (flow_dev[i] == dev && flow_type[i] == stype) begin
                found = 1'b1;
                slot  = i;
              end
            end
          end
          if (!found && !have_free) begin
            v.status = ST_FULL;
          end else begin
            if (!found) begin
              wipe_flow(slot);
              flow_used[slot] = 1'b1;
              flow_dev[slot]  = dev;
              flow_type[slot] = stype;
            end
            v.prior = flow_time[slot];
            // Baseline reset reasons apply only to a strictly backward timestamp.
            if (ts > v.prior)
              v.status = ST_OK;
            else if (ts == v.prior)
              v.status = ST_NON_MONO;
            else if (flow_peer[slot] != '0 && peer != '0 && flow_peer[slot] != peer)
              v.status = ST_RESET_PEER;
            else if (ts < reboot_small && v.prior > reboot_small)
              v.status = ST_RESET_REBOOT;
            else if (flow_wall[slot] != '0 && wall >= flow_wall[slot] &&
                     (wall - flow_wall[slot]) > gap_limit)
              v.status = ST_RESET_GAP;
            else
              v.status = ST_NON_MONO;
            if (v.status != ST_NON_MONO) begin
              flow_time[slot] = ts;
              flow_wall[slot] = wall;
              if (peer != '0)
                flow_peer[slot] = peer;
            end
          end
        end
      end
      KIND_CLR_DEV: begin
        for (int i = 0; i < TABLE_ENTRIES; i++)
          if (flow_used[i] && flow_dev[i] == dev)
            wipe_flow(i);
      end
      KIND_CLR_ALL: begin
        for (int i = 0; i < TABLE_ENTRIES; i++)
          wipe_flow(i);
      end
      default: ;
    endcase
    return v;
  endfunction

  // Offer one word after a random gap, hold it until accepted, then log its verdict.
  // Valid stays high into the next call, so back-to-back words need no extra edge.
  task automatic send_word(input logic [1:0] kind, input logic [DEV_W-1:0] dev,
                           input logic [TYPE_W-1:0] stype, input logic [TIME_W-1:0] ts,
                           input logic [TIME_W-1:0] wall, input logic [PEER_W-1:0] peer);
    int unsigned gap;
    gap = src_idle_on ? $urandom_range(0, 7) : 0;
    @(negedge clk_i);
    if (gap != 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {{PAD_W{1'b0}}, peer, wall, ts, stype, dev};
    s_axis_tuser_i  <= kind;
    do @(posedge clk_i); while (!s_axis_tready_o);
    pending_verdicts.push_back(judge_word(kind, dev, stype, ts, wall, peer));
  endtask

  // Drop valid and wait for every outstanding result.
  task automatic drain_results();
    int unsigned waited;
    waited = 0;
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (pending_verdicts.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
  endtask

  // Register write; only called with the checker idle.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == REG_REBOOT_SMALL)
      reboot_small = val;
    else
      gap_limit = val;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // One random word: mostly checks on a small set of flows, with timestamps steered
  // around the stored value so every verdict shows up, plus clears and noise.
  task automatic random_word();
    int unsigned       pick;
    int unsigned       r;
    logic [1:0]        kind;
    logic [DEV_W-1:0]  dev;
    logic [TYPE_W-1:0] stype;
    logic [TIME_W-1:0] last;
    logic [TIME_W-1:0] last_wall;
    logic [TIME_W-1:0] ts;
    logic [TIME_W-1:0] wall;
    logic [PEER_W-1:0] peer;
    pick  = $urandom_range(0, DEV_POOL - 1);
    dev   = ($urandom_range(0, 19) == 0) ? $urandom : dev_pool[pick];
    stype = TYPE_W'($urandom_range(0, 3));
    r     = $urandom_range(0, 99);
    kind  = (r < 3) ? KIND_CLR_DEV : (r < 4) ? KIND_CLR_ALL : (r < 5) ? KIND_UNDEF : KIND_CHECK;
    last      = '0;
    last_wall = '0;
    for (int i = 0; i < TABLE_ENTRIES; i++)
      if (flow_used[i] && flow_dev[i] == dev && flow_type[i] == stype) begin
        last      = flow_time[i];
        last_wall = flow_wall[i];
      end
    r = $urandom_range(0, 99);
    if (r < 55)
      ts = last + TIME_W'($urandom_range(1, 2000));
    else if (r < 62)
      ts = last + TIME_W'({$urandom_range(0, 3), $urandom});
    else if (r < 67)
      ts = last;
    else if (r < 80)
      ts = last - TIME_W'($urandom_range(1, 3000));
    else if (r < 88)
      ts = (reboot_small > 1) ? TIME_W'($urandom_range(1, reboot_small - 1)) : TIME_W'(1);
    else if (r < 93)
      ts = '0;
    else
      ts = TIME_W'({$urandom, $urandom});
    // Advance local uptime; now and then jump far, step back, or land on the gap edge.
    r = $urandom_range(0, 99);
    if (r < 55)
      wall_clock = wall_clock + TIME_W'($urandom_range(0, 1500));
    else if (r < 70)
      wall_clock = wall_clock + TIME_W'($urandom_range(3000, 30000));
    else if (r < 80)
      wall_clock = wall_clock + TIME_W'({$urandom_range(0, 3), $urandom});
    else if (r < 85)
      wall_clock = wall_clock - TIME_W'($urandom_range(0, 100000));
    else if (r < 88)
      wall_clock = TIME_W'({$urandom, $urandom});
    wall = (r >= 88) ? last_wall + TIME_W'(gap_limit) + TIME_W'($urandom_range(0, 2))
                       - TIME_W'(1) : wall_clock;
    r = $urandom_range(0, 99);
    if (r < 60)
      peer = peer_pool[pick % PEER_POOL];
    else if (r < 75)
      peer = peer_pool[$urandom_range(0, PEER_POOL - 1)];
    else if (r < 90)
      peer = '0;
    else
      peer = $urandom;
    send_word(kind, dev, stype, ts, wall, peer);
  endtask

  // Walk flows of two devices through each verdict but full, then clears and the undefined kind.
  task automatic test_directed_flows();
    logic [DEV_W-1:0]  dev_hi;
    logic [PEER_W-1:0] peer_a;
    logic [PEER_W-1:0] peer_b;
    dev_hi = '1;
    peer_a = 32'h0A00_0001;
    peer_b = 32'hC0A8_0102;
    write_reg(REG_REBOOT_SMALL, REBOOT_SMALL_RST);
    write_reg(REG_RECONNECT_GAP, RECONNECT_GAP_RST);
    send_word(KIND_CHECK, dev_hi, 2'd0, 48'd100,   48'd1000,  peer_a);  // new flow
    send_word(KIND_CHECK, dev_hi, 2'd0, 48'd100,   48'd1200,  peer_a);  // equal stamp
    send_word(KIND_CHECK, dev_hi, 2'd0, 48'd0,     48'd1300,  peer_a);  // zero stamp
    send_word(KIND_CHECK, dev_hi, 2'd0, 48'd50,    48'd1000,  peer_b);  // peer changed
    send_word(KIND_CHECK, dev_hi, 2'd0, 48'd40,    48'd1500,  '0);      // zero peer, no reason
    send_word(KIND_CHECK, dev_hi, 2'd0, 48'd70000, 48'd2000,  '0);      // peer kept
    send_word(KIND_CHECK, dev_hi, 2'd0, 48'd10,    48'd2500,  peer_b);  // reboot
    send_word(KIND_CHECK, dev_hi, 2'd0, 48'd5,     48'd7501,  peer_b);  // gap just over
    send_word(KIND_CHECK, dev_hi, 2'd0, 48'd4,     48'd12501, peer_b);  // gap exactly at limit
    send_word(KIND_CHECK, dev_hi, 2'd0, 48'd3,     48'd100,   peer_b);  // wall went backward
    send_word(KIND_CHECK, dev_hi, 2'd1, '1, '1, '1);                    // field maxima
    send_word(KIND_CHECK, dev_hi, 2'd1, 48'd1,     48'd5,     '1);      // reboot from the top
    send_word(KIND_CHECK, '0,     2'd3, 48'd500,   '0,        '0);      // stored wall zero
    send_word(KIND_CHECK, '0,     2'd3, 48'd400,   '1,        '0);      // zero wall never a gap
    send_word(KIND_CHECK, '0,     2'd2, '1,        '1,        32'd1);
    send_word(KIND_CLR_DEV, dev_hi, 2'd2, '1, '1, '1);                  // clear both types of dev
    send_word(KIND_CHECK, dev_hi, 2'd0, 48'd1,     48'd1,     peer_a);  // new again after clear
    send_word(KIND_UNDEF, '1, '1, '1, '1, '1);
    send_word(KIND_CHECK, '0,     2'd3, 48'd600,   48'd9000,  '0);      // untouched by clear
    send_word(KIND_CLR_ALL, '0, '0, '0, '0, '0);
    send_word(KIND_CHECK, '0,     2'd3, 48'd1,     48'd1,     '0);      // table empty again
    drain_results();
  endtask

  // Fill every entry, overflow, then free part of the table and reclaim it.
  task automatic test_table_full();
    send_word(KIND_CLR_ALL, '0, '0, '0, '0, '0);
    for (int d = 0; d < TABLE_ENTRIES / 4; d++)
      for (int t = 0; t < 4; t++)
        send_word(KIND_CHECK, 32'h1000_0000 + DEV_W'(d), TYPE_W'(t),
                  48'd1000 + TIME_W'(d), 48'd10, '0);
    send_word(KIND_CHECK, 32'h2000_0000, 2'd0, 48'd5, 48'd20, '0);       // no room
    send_word(KIND_CHECK, 32'h1000_0003, 2'd2, 48'd5000, 48'd30, '0);    // known flow still works
    send_word(KIND_CLR_DEV, 32'h1000_0001, 2'd0, '0, '0, '0);
    send_word(KIND_CHECK, 32'h2000_0000, 2'd1, 48'd5, 48'd40, '0);       // lowest freed entry
    send_word(KIND_CLR_ALL, '0, '0, '0, '0, '0);
    drain_results();
  endtask

  // Hold the sink off for a long stretch while words keep coming, then pause the source.
  task automatic test_backpressure();
    src_idle_on = 1'b0;
    sink_hold   = 300;
    repeat (16) random_word();
    drain_results();
    src_idle_on = 1'b1;
  endtask

  // Set both registers, then run random traffic with idling switched per stretch.
  task automatic test_random_traffic(input logic [CFG_W-1:0] small_ts,
                                     input logic [CFG_W-1:0] gap, input int unsigned n_words);
    drain_results();
    write_reg(REG_REBOOT_SMALL, small_ts);
    write_reg(REG_RECONNECT_GAP, gap);
    for (int unsigned k = 0; k < n_words; k++) begin
      if (k % 50 == 0) begin
        src_idle_on  = ($urandom_range(0, 3) != 0);
        sink_idle_on = ($urandom_range(0, 3) != 0);
      end
      random_word();
    end
    drain_results();
    src_idle_on  = 1'b1;
    sink_idle_on = 1'b1;
  endtask

  // Result sink: stall before each word, or take a long hold when a test asks for one.
  initial begin : result_sink
    int unsigned stall;
    m_axis_tready_i = 1'b0;
    forever begin
      stall = sink_idle_on ? $urandom_range(0, 7) : 0;
      if (sink_hold != 0) begin
        stall     = sink_hold;
        sink_hold = 0;
      end
      @(negedge clk_i);
      if (stall != 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid_o && m_axis_tready_i));
    end
  end

  // Compare each accepted result word with the oldest outstanding verdict.
  always @(posedge clk_i) begin : result_check
    verdict_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_verdicts.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result word: status %0d prior %0h",
                   m_axis_tdata_o[2:0], m_axis_tdata_o[3 +: TIME_W]);
      end else begin
        want = pending_verdicts.pop_front();
        if (m_axis_tdata_o[2:0] !== want.status ||
            m_axis_tdata_o[3 +: TIME_W] !== want.prior) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("result mismatch: status exp %0d got %0d, prior exp %0h got %0h",
                     want.status, m_axis_tdata_o[2:0], want.prior, m_axis_tdata_o[3 +: TIME_W]);
        end
      end
    end
  end

  initial begin : watchdog
    #(RUN_LIMIT);
    $display("DONE: errors detected");
    $finish;
  end

  initial begin : main_sequence
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = KIND_CHECK;
    cfg_valid_i     = 1'b0;
    cfg_index_i     = REG_REBOOT_SMALL;
    cfg_data_i      = '0;
    for (int i = 0; i < TABLE_ENTRIES; i++)
      wipe_flow(i);
    for (int i = 0; i < DEV_POOL; i++)
      dev_pool[i] = $urandom;
    for (int i = 0; i < PEER_POOL; i++)
      peer_pool[i] = $urandom;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed_flows();
    test_table_full();
    test_backpressure();
    test_random_traffic(REBOOT_SMALL_RST, RECONNECT_GAP_RST, 250);
    test_random_traffic('0, '0, 250);
    test_random_traffic('1, '1, 250);
    test_random_traffic(32'd1000, 32'd100, 250);
    test_random_traffic($urandom_range(1, 200000), $urandom_range(0, 20000), 250);

    // Let any stray result word show up before the verdict.
    repeat (2 * TABLE_ENTRIES + 8) @(posedge clk_i);
    mismatch_count += pending_verdicts.size();
    if (mismatch_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

>>> sim.f
rtl/pftmc_pkg.sv
rtl/per_flow_timestamp_monotonic_check.sv
sim/tb_top.sv
